// ===== hw/rtl/fpa_pkg.sv =====
// Shared action codes, bounds and pipeline payload types for the fixed-point ALU
`timescale 1ns / 1ps

package fpa_pkg;

   localparam logic [3:0] ACT_ADD      = 4'd0;
   localparam logic [3:0] ACT_SUB      = 4'd1;
   localparam logic [3:0] ACT_MUL      = 4'd2;
   localparam logic [3:0] ACT_DIV      = 4'd3;
   localparam logic [3:0] ACT_MAX      = 4'd4;
   localparam logic [3:0] ACT_MIN      = 4'd5;
   localparam logic [3:0] ACT_INC      = 4'd6;
   localparam logic [3:0] ACT_DEC      = 4'd7;
   localparam logic [3:0] ACT_FROM_INT = 4'd8;
   localparam logic [3:0] ACT_TO_INT   = 4'd9;

   localparam logic signed [31:0] RAW_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] RAW_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] res;
      logic               ovf;
      logic               dz;
      logic               is_mul;
      logic               is_div;
      logic               neg;
      logic               gt;
      logic               lt;
      logic               eq;
   } fpa_tag_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dsr;
      logic [32:0] quo;
      logic        big;
   } fpa_div_type;

   typedef struct packed {
      logic signed [31:0] result_raw;
      logic               a_greater;
      logic               a_less;
      logic               a_equal;
      logic               overflow;
      logic               div_by_zero;
   } fpa_rsp_type;

endpackage

// ===== hw/rtl/fpa_req_if.sv =====
// Request channel: action and two raw operands with valid/ready
`timescale 1ns / 1ps

interface fpa_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         action;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, action, operand_a, operand_b, input ready);
   modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

// ===== hw/rtl/fpa_rsp_if.sv =====
// Response channel: raw result and status flags with valid/ready
`timescale 1ns / 1ps

interface fpa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_raw;
   logic               a_greater;
   logic               a_less;
   logic               a_equal;
   logic               overflow;
   logic               div_by_zero;

   modport source (output valid, result_raw, a_greater, a_less, a_equal, overflow,
                   div_by_zero, input ready);
   modport sink   (input valid, result_raw, a_greater, a_less, a_equal, overflow,
                   div_by_zero, output ready);
endinterface

// ===== hw/rtl/fpa_front.sv =====
// Front stages: decode, simple operations, pipelined multiply and divider set-up
`timescale 1ns / 1ps

module fpa_front #(
   parameter int FRAC_BITS = 8,
   parameter int NUM_W     = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [3:0]          in_action,
   input  logic signed [31:0]  in_a,
   input  logic signed [31:0]  in_b,
   output logic                out_valid,
   output fpa_pkg::fpa_tag_type out_tag,
   output fpa_pkg::fpa_div_type out_div,
   output logic [NUM_W-1:0]    out_num
);
   import fpa_pkg::*;

   typedef struct packed {
      logic signed [31:0] res;
      logic               ovf;
   } fpa_sat_type;

   localparam logic [63:0] MUL_HALF = (64'd1 << FRAC_BITS) >> 1;

   function automatic fpa_sat_type sat_to_raw(input logic signed [63:0] v);
      fpa_sat_type r;
      if (v > 64'(RAW_MAX)) begin
         r.res = RAW_MAX;
         r.ovf = 1'b1;
      end else if (v < 64'(RAW_MIN)) begin
         r.res = RAW_MIN;
         r.ovf = 1'b1;
      end else begin
         r.res = v[31:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   logic signed [32:0] sum_w;
   logic signed [32:0] diff_w;
   logic signed [32:0] inc_w;
   logic signed [32:0] dec_w;
   logic signed [63:0] wide;
   fpa_sat_type        sat;
   logic [31:0]        abs_a;
   logic [31:0]        abs_b;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   fpa_tag_type        s1_tag_in, s1_tag_ff, s2_tag_ff, s3_tag_in, s3_tag_ff;
   fpa_div_type        s1_div_in, s1_div_ff, s2_div_ff, s3_div_ff;
   logic [NUM_W-1:0]   s1_num_in, s1_num_ff, s2_num_ff, s3_num_ff;
   logic signed [63:0] s1_prod_in, s1_prod_ff;
   logic [63:0]        s2_mag_in, s2_mag_ff;
   logic               s2_mneg_ff;
   logic [63:0]        mul_q;

   assign sum_w  = 33'(in_a) + 33'(in_b);
   assign diff_w = 33'(in_a) - 33'(in_b);
   assign inc_w  = 33'(in_a) + 33'sd1;
   assign dec_w  = 33'(in_a) - 33'sd1;
   assign abs_a  = in_a[31] ? (~in_a + 32'd1) : in_a;
   assign abs_b  = in_b[31] ? (~in_b + 32'd1) : in_b;

   always_comb begin
      unique case (in_action)
         ACT_ADD:      wide = 64'(sum_w);
         ACT_SUB:      wide = 64'(diff_w);
         ACT_MAX:      wide = 64'((in_a > in_b) ? in_a : in_b);
         ACT_MIN:      wide = 64'((in_a < in_b) ? in_a : in_b);
         ACT_INC:      wide = 64'(inc_w);
         ACT_DEC:      wide = 64'(dec_w);
         ACT_FROM_INT: wide = 64'(in_a) <<< FRAC_BITS;
         ACT_TO_INT:   wide = 64'(in_a >>> FRAC_BITS);
         default:      wide = '0;
      endcase
      sat = sat_to_raw(wide);

      s1_tag_in.res    = sat.res;
      s1_tag_in.ovf    = sat.ovf;
      s1_tag_in.dz     = (in_action == ACT_DIV) && (in_b == 32'sd0);
      s1_tag_in.is_mul = (in_action == ACT_MUL);
      s1_tag_in.is_div = (in_action == ACT_DIV) && (in_b != 32'sd0);
      s1_tag_in.neg    = in_a[31] ^ in_b[31];
      s1_tag_in.gt     = in_a > in_b;
      s1_tag_in.lt     = in_a < in_b;
      s1_tag_in.eq     = in_a == in_b;

      s1_div_in.rem = '0;
      s1_div_in.dsr = abs_b;
      s1_div_in.quo = '0;
      s1_div_in.big = 1'b0;
      s1_num_in     = NUM_W'(abs_a) << FRAC_BITS;
      s1_prod_in    = 64'(in_a) * 64'(in_b);
   end

   assign s2_mag_in = s1_prod_ff[63] ? (~s1_prod_ff + 64'd1) : s1_prod_ff;
   assign mul_q     = (s2_mag_ff + MUL_HALF) >> FRAC_BITS;

   always_comb begin
      s3_tag_in = s2_tag_ff;
      if (s2_tag_ff.is_mul) begin
         if (s2_mneg_ff) begin
            s3_tag_in.ovf = mul_q > 64'h8000_0000;
            s3_tag_in.res = s3_tag_in.ovf ? RAW_MIN : (~mul_q[31:0] + 32'd1);
         end else begin
            s3_tag_in.ovf = mul_q > 64'h7FFF_FFFF;
            s3_tag_in.res = s3_tag_in.ovf ? RAW_MAX : mul_q[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff  <= s1_tag_in;
         s1_div_ff  <= s1_div_in;
         s1_num_ff  <= s1_num_in;
         s1_prod_ff <= s1_prod_in;
         s2_tag_ff  <= s1_tag_ff;
         s2_div_ff  <= s1_div_ff;
         s2_num_ff  <= s1_num_ff;
         s2_mag_ff  <= s2_mag_in;
         s2_mneg_ff <= s1_prod_ff[63];
         s3_tag_ff  <= s3_tag_in;
         s3_div_ff  <= s2_div_ff;
         s3_num_ff  <= s2_num_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_tag   = s3_tag_ff;
   assign out_div   = s3_div_ff;
   assign out_num   = s3_num_ff;

endmodule

// ===== hw/rtl/fpa_div_cell.sv =====
// Divider cell: one restoring quotient bit per cell, payload handed on each cycle that adv is high
`timescale 1ns / 1ps

module fpa_div_cell #(
   parameter int NUM_W = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  fpa_pkg::fpa_tag_type in_tag,
   input  fpa_pkg::fpa_div_type in_div,
   input  logic [NUM_W-1:0]     in_num,
   output logic                 out_valid,
   output fpa_pkg::fpa_tag_type out_tag,
   output fpa_pkg::fpa_div_type out_div,
   output logic [NUM_W-1:0]     out_num
);
   import fpa_pkg::*;

   logic [32:0]      trial;
   logic             fit;
   logic             valid_ff;
   fpa_tag_type      tag_ff;
   fpa_div_type      div_in, div_ff;
   logic [NUM_W-1:0] num_in, num_ff;

   always_comb begin
      trial      = {in_div.rem, in_num[NUM_W-1]};
      fit        = trial >= {1'b0, in_div.dsr};
      div_in.rem = fit ? 32'(trial - {1'b0, in_div.dsr}) : 32'(trial);
      div_in.dsr = in_div.dsr;
      div_in.quo = {in_div.quo[31:0], fit};
      div_in.big = in_div.big | in_div.quo[32];
      num_in     = in_num << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff <= in_tag;
         div_ff <= div_in;
         num_ff <= num_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_div   = div_ff;
   assign out_num   = num_ff;

endmodule

// ===== hw/rtl/fpa_back.sv =====
// Back stage: quotient rounding register, then saturation and sign of a divide result; other results pass through
`timescale 1ns / 1ps

module fpa_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  fpa_pkg::fpa_tag_type in_tag,
   input  fpa_pkg::fpa_div_type in_div,
   output logic                 out_valid,
   output fpa_pkg::fpa_rsp_type out_rsp
);
   import fpa_pkg::*;

   localparam logic [33:0] POS_LIM = 34'h0_7FFF_FFFF;
   localparam logic [33:0] NEG_LIM = 34'h0_8000_0000;

   logic        rnd;
   logic [33:0] q_in, q_ff;
   logic        big_ff;
   logic        valid_ff;
   fpa_tag_type tag_ff;
   logic        dov;

   assign rnd  = {in_div.rem, 1'b0} >= {1'b0, in_div.dsr};
   assign q_in = {1'b0, in_div.quo} + 34'(rnd);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff <= in_tag;
         q_ff   <= q_in;
         big_ff <= in_div.big;
      end
   end

   always_comb begin
      dov = big_ff || (q_ff > (tag_ff.neg ? NEG_LIM : POS_LIM));
      out_rsp.a_greater   = tag_ff.gt;
      out_rsp.a_less      = tag_ff.lt;
      out_rsp.a_equal     = tag_ff.eq;
      out_rsp.div_by_zero = tag_ff.dz;
      if (tag_ff.is_div) begin
         out_rsp.overflow = dov;
         if (dov) begin
            out_rsp.result_raw = tag_ff.neg ? RAW_MIN : RAW_MAX;
         end else begin
            out_rsp.result_raw = tag_ff.neg ? (~q_ff[31:0] + 32'd1) : q_ff[31:0];
         end
      end else begin
         out_rsp.overflow   = tag_ff.ovf;
         out_rsp.result_raw = tag_ff.res;
      end
   end

   assign out_valid = valid_ff;

endmodule

// ===== hw/rtl/fixed_point_alu.sv =====
// A request passes the front registers, the divider cells, the back register and the output register in turn.
// Throughput: one item per cycle while the skid stage is empty; the divider is a chain of 32 + FRAC_BITS cells,
// one quotient bit each, and every item walks the same chain so order is kept.
// A two-entry output register and skid stage decouple response stalls from request ready.
// Reset (synchronous, active high) empties every stage; no clearing pass is needed.
`timescale 1ns / 1ps

module fixed_point_alu #(
   parameter int FRAC_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   fpa_req_if.sink   req_bus,
   fpa_rsp_if.source rsp_bus
);
   import fpa_pkg::*;

   localparam int NUM_W = 32 + FRAC_BITS;

   logic             adv;
   logic             chain_valid [NUM_W+1];
   fpa_tag_type      chain_tag   [NUM_W+1];
   fpa_div_type      chain_div   [NUM_W+1];
   logic [NUM_W-1:0] chain_num   [NUM_W+1];

   logic             up_valid;
   fpa_rsp_type      up_data;
   logic             out_valid_in, out_valid_ff;
   logic             skid_valid_in, skid_valid_ff;
   fpa_rsp_type      out_in, out_ff;
   fpa_rsp_type      skid_in, skid_ff;

   assign adv           = !skid_valid_ff;
   assign req_bus.ready = adv;

   fpa_front #(
      .FRAC_BITS (FRAC_BITS),
      .NUM_W     (NUM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_bus.valid),
      .in_action (req_bus.action),
      .in_a      (req_bus.operand_a),
      .in_b      (req_bus.operand_b),
      .out_valid (chain_valid[0]),
      .out_tag   (chain_tag[0]),
      .out_div   (chain_div[0]),
      .out_num   (chain_num[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      fpa_div_cell #(
         .NUM_W (NUM_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_tag    (chain_tag[i]),
         .in_div    (chain_div[i]),
         .in_num    (chain_num[i]),
         .out_valid (chain_valid[i+1]),
         .out_tag   (chain_tag[i+1]),
         .out_div   (chain_div[i+1]),
         .out_num   (chain_num[i+1])
      );
   end

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (chain_valid[NUM_W]),
      .in_tag    (chain_tag[NUM_W]),
      .in_div    (chain_div[NUM_W]),
      .out_valid (up_valid),
      .out_rsp   (up_data)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = up_valid;
            out_in       = up_data;
         end
      end else if (up_valid && adv) begin
         // hold the stalled response, park the arriving one
         skid_valid_in = 1'b1;
         skid_in       = up_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.result_raw  = out_ff.result_raw;
   assign rsp_bus.a_greater   = out_ff.a_greater;
   assign rsp_bus.a_less      = out_ff.a_less;
   assign rsp_bus.a_equal     = out_ff.a_equal;
   assign rsp_bus.overflow    = out_ff.overflow;
   assign rsp_bus.div_by_zero = out_ff.div_by_zero;

`ifndef NO_ASSERTIONS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready && up_valid && adv) |=> skid_valid_ff)
      else $error("arriving response dropped during a stall");

   a_one_compare: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot({out_ff.a_greater, out_ff.a_less, out_ff.a_equal}))
      else $error("compare flags not exclusive");

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.div_by_zero) |-> (out_ff.result_raw == 32'sd0 && !out_ff.overflow))
      else $error("divide by zero result not cleared");
`endif

endmodule
